@@ hw/rtl/arm_pkg.sv @@
package arm_pkg;

  // configuration register map
  typedef enum logic [2:0] {
    REG_MODE         = 3'd0,
    REG_OUTER_COUNT  = 3'd1,
    REG_REDUCED_LEN  = 3'd2,
    REG_INNER_COUNT  = 3'd3,
    REG_LENGTH_RECIP = 3'd4
  } cfg_reg_t;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;

  localparam int OUTER_W     = 16;
  localparam int RED_CNT_W   = 13;
  localparam int INNER_CNT_W = 11;
  localparam int RECIP_W     = 17;
  localparam int INDEX_W     = 26;
  localparam int FRAC_BITS   = 16;

  localparam logic               MODE_MAX   = 1'b0;
  localparam logic               MODE_MEAN  = 1'b1;
  localparam logic [RECIP_W-1:0] RECIP_ONE  = 17'h10000;

  // sums clamp at +-2^40
  localparam logic signed [63:0] ACC_LIMIT  = 64'sd1099511627776;

  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  typedef struct packed {
    logic first;     // first element along the reduced axis
    logic last_red;  // last element along the reduced axis: emits a result
    logic done;      // final result of the tensor
  } cmd_flags_t;

  localparam int FLAGS_W = $bits(cmd_flags_t);

  typedef struct packed {
    logic               mode;
    logic [RECIP_W-1:0] recip;  // clamped to 1.0
  } cfg_live_t;

endpackage

@@ hw/rtl/arm_ram.sv @@
module arm_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/arm_fifo.sv @@
module arm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [W-1:0]                 wdata,
  output logic                         full,
  input  logic                         pop,
  output logic [W-1:0]                 rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ hw/rtl/arm_front.sv @@
module arm_front #(
  parameter int INNER_MAX  = 1024,
  parameter int LENGTH_MAX = 4096
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // configuration
  input  logic                                       cfg_valid,
  input  logic [arm_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [arm_pkg::CFG_DATA_W-1:0]             cfg_data,
  // input requests
  input  logic                                       push,
  output logic                                       full,
  // command queue
  input  logic                                       q_full,
  output logic                                       q_push,
  output arm_pkg::cmd_flags_t                        q_flags,
  output logic [((INNER_MAX > 1) ? $clog2(INNER_MAX) : 1)-1:0] q_slot,
  output logic [arm_pkg::OUTER_W-1:0]                q_outer,
  // live settings for the back end
  output arm_pkg::cfg_live_t                         cfg_live,
  output logic [$clog2(INNER_MAX+1)-1:0]             inner_n
);

  localparam int INNER_W   = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
  localparam int INNER_N_W = $clog2(INNER_MAX + 1);
  localparam int LEN_W     = (LENGTH_MAX > 1) ? $clog2(LENGTH_MAX) : 1;
  localparam int LEN_N_W   = $clog2(LENGTH_MAX + 1);
  localparam int OW        = arm_pkg::OUTER_W;

  logic                            mode_r;
  logic [OW-1:0]                   outer_cnt_r;
  logic [arm_pkg::RED_CNT_W-1:0]   red_len_r;
  logic [arm_pkg::INNER_CNT_W-1:0] inner_cnt_r;
  logic [arm_pkg::RECIP_W-1:0]     recip_r;

  logic [INNER_W-1:0] inner_pos_r, inner_pos_nxt;
  logic [LEN_W-1:0]   red_pos_r, red_pos_nxt;
  logic [OW-1:0]      outer_pos_r, outer_pos_nxt;

  logic [OW-1:0]      outer_n;
  logic [LEN_N_W-1:0] len_n;
  logic               accept;
  logic               last_inner, last_red, last_outer;

  // zero counts act as one, oversized counts clamp
  always_comb begin
    outer_n = (outer_cnt_r == '0) ? OW'(1) : outer_cnt_r;
    if (red_len_r == '0) begin
      len_n = LEN_N_W'(1);
    end else if (red_len_r > LENGTH_MAX) begin
      len_n = LEN_N_W'(LENGTH_MAX);
    end else begin
      len_n = LEN_N_W'(red_len_r);
    end
    if (inner_cnt_r == '0) begin
      inner_n = INNER_N_W'(1);
    end else if (inner_cnt_r > INNER_MAX) begin
      inner_n = INNER_N_W'(INNER_MAX);
    end else begin
      inner_n = INNER_N_W'(inner_cnt_r);
    end
    cfg_live.mode  = mode_r;
    cfg_live.recip = (recip_r > arm_pkg::RECIP_ONE) ? arm_pkg::RECIP_ONE : recip_r;
  end

  assign accept = push && !q_full;
  assign full   = q_full;
  assign q_push = accept;

  // a position at or past its new end counts as the end
  assign last_inner = (INNER_N_W'(inner_pos_r) + INNER_N_W'(1)) >= inner_n;
  assign last_red   = (LEN_N_W'(red_pos_r) + LEN_N_W'(1)) >= len_n;
  assign last_outer = ((OW+1)'(outer_pos_r) + (OW+1)'(1)) >= (OW+1)'(outer_n);

  assign q_flags.first    = (red_pos_r == '0);
  assign q_flags.last_red = last_red;
  assign q_flags.done     = last_red && last_inner && last_outer;
  assign q_slot           = inner_pos_r;
  assign q_outer          = outer_pos_r;

  always_comb begin
    inner_pos_nxt = inner_pos_r;
    red_pos_nxt   = red_pos_r;
    outer_pos_nxt = outer_pos_r;
    if (accept) begin
      if (!last_inner) begin
        inner_pos_nxt = inner_pos_r + INNER_W'(1);
      end else begin
        inner_pos_nxt = '0;
        if (!last_red) begin
          red_pos_nxt = red_pos_r + LEN_W'(1);
        end else begin
          red_pos_nxt   = '0;
          outer_pos_nxt = last_outer ? '0 : outer_pos_r + OW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= arm_pkg::MODE_MAX;
      outer_cnt_r <= OW'(1);
      red_len_r   <= arm_pkg::RED_CNT_W'(1);
      inner_cnt_r <= arm_pkg::INNER_CNT_W'(1);
      recip_r     <= arm_pkg::RECIP_ONE;
      inner_pos_r <= '0;
      red_pos_r   <= '0;
      outer_pos_r <= '0;
    end else begin
      inner_pos_r <= inner_pos_nxt;
      red_pos_r   <= red_pos_nxt;
      outer_pos_r <= outer_pos_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          arm_pkg::REG_MODE:         mode_r      <= cfg_data[0];
          arm_pkg::REG_OUTER_COUNT:  outer_cnt_r <= cfg_data[OW-1:0];
          arm_pkg::REG_REDUCED_LEN:  red_len_r   <= cfg_data[arm_pkg::RED_CNT_W-1:0];
          arm_pkg::REG_INNER_COUNT:  inner_cnt_r <= cfg_data[arm_pkg::INNER_CNT_W-1:0];
          arm_pkg::REG_LENGTH_RECIP: recip_r     <= cfg_data[arm_pkg::RECIP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  a_done_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && q_flags.done) |=>
      (inner_pos_r == '0 && red_pos_r == '0 && outer_pos_r == '0))
    else $error("positions not rewound after tensor end");

  a_result_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && q_flags.last_red && !last_inner) |=> (red_pos_r == $past(red_pos_r)))
    else $error("reduced position moved inside a row");

endmodule

@@ hw/rtl/arm_back.sv @@
module arm_back #(
  parameter int INNER_MAX   = 1024,
  parameter int LENGTH_MAX  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  arm_pkg::cfg_live_t                         cfg_live,
  input  logic [$clog2(INNER_MAX+1)-1:0]             inner_n,
  // command queue
  input  logic                                       q_empty,
  output logic                                       q_pop,
  input  arm_pkg::cmd_flags_t                        q_flags,
  input  logic signed [SAMPLE_BITS-1:0]              q_sample,
  input  logic [((INNER_MAX > 1) ? $clog2(INNER_MAX) : 1)-1:0] q_slot,
  input  logic [arm_pkg::OUTER_W-1:0]                q_outer,
  // result queue
  input  logic [$clog2(arm_pkg::OUT_DEPTH+1)-1:0]    res_level,
  output logic                                       out_push,
  output logic [SAMPLE_BITS-1:0]                     out_value,
  output logic [arm_pkg::INDEX_W-1:0]                out_index,
  output logic                                       out_done
);

  localparam int INNER_W   = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
  localparam int INNER_N_W = $clog2(INNER_MAX + 1);
  localparam int ACC_W     = SAMPLE_BITS + ((LENGTH_MAX > 1) ? $clog2(LENGTH_MAX) : 0);
  localparam int SUM_W     = ACC_W + 1;
  localparam int PROD_W    = ACC_W + arm_pkg::RECIP_W + 1;
  localparam int BASE_W    = arm_pkg::OUTER_W + INNER_N_W;
  localparam int IDX_SUM_W = BASE_W + 1;
  localparam int OCNT_W    = $clog2(arm_pkg::OUT_DEPTH + 1);
  localparam int CRED_W    = OCNT_W + 2;

  localparam logic signed [PROD_W-1:0] SMP_HI =
    PROD_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [PROD_W-1:0] SMP_LO =
    PROD_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  // execute stage: accumulator read-modify-write
  logic                        ex_valid_r;
  arm_pkg::cmd_flags_t         ex_flags_r;
  logic signed [SAMPLE_BITS-1:0] ex_sample_r;
  logic [INNER_W-1:0]          ex_slot_r;
  logic [arm_pkg::OUTER_W-1:0] ex_outer_r;
  logic                        byp_r, byp_nxt;
  logic signed [ACC_W-1:0]     byp_data_r;
  logic [ACC_W-1:0]            ram_rdata;
  logic signed [ACC_W-1:0]     operand, x_ext, acc_new;
  logic signed [SUM_W-1:0]     sum_s;
  logic signed [63:0]          sum64;

  // multiply stage
  logic                        mul_valid_r;
  logic signed [ACC_W-1:0]     mul_acc_r;
  logic [INNER_W-1:0]          mul_inner_r;
  logic [arm_pkg::OUTER_W-1:0] mul_outer_r;
  logic                        mul_done_r;
  logic signed [PROD_W-1:0]    prod_nxt;
  logic [BASE_W-1:0]           base_nxt;

  // finish stage
  logic                        fin_valid_r;
  logic signed [PROD_W-1:0]    fin_prod_r;
  logic [BASE_W-1:0]           fin_base_r;
  logic [INNER_W-1:0]          fin_inner_r;
  logic [SAMPLE_BITS-1:0]      fin_max_r;
  logic                        fin_done_r;
  logic signed [PROD_W-1:0]    shifted;
  logic [SAMPLE_BITS-1:0]      mean_val;
  logic [IDX_SUM_W-1:0]        idx_sum;

  logic [CRED_W-1:0]           credit;

  // pop only when the result queue has room for everything in flight
  assign credit = CRED_W'(res_level)
                + CRED_W'(ex_valid_r && ex_flags_r.last_red)
                + CRED_W'(mul_valid_r)
                + CRED_W'(fin_valid_r);
  assign q_pop  = !q_empty && (credit < CRED_W'(arm_pkg::OUT_DEPTH));

  arm_ram #(
    .W     (ACC_W),
    .DEPTH (INNER_MAX)
  ) u_acc_ram (
    .clk   (clk),
    .we    (ex_valid_r),
    .waddr (ex_slot_r),
    .wdata (acc_new),
    .raddr (q_slot),
    .rdata (ram_rdata)
  );

  always_comb begin
    operand = byp_r ? byp_data_r : $signed(ram_rdata);
    x_ext   = ACC_W'(ex_sample_r);
    sum_s   = SUM_W'(operand) + SUM_W'(x_ext);
    sum64   = 64'(sum_s);
    if (ex_flags_r.first) begin
      acc_new = x_ext;
    end else if (cfg_live.mode == arm_pkg::MODE_MAX) begin
      acc_new = (x_ext > operand) ? x_ext : operand;
    end else if (sum64 > arm_pkg::ACC_LIMIT) begin
      acc_new = ACC_W'(arm_pkg::ACC_LIMIT);
    end else if (sum64 < -arm_pkg::ACC_LIMIT) begin
      acc_new = ACC_W'(-arm_pkg::ACC_LIMIT);
    end else begin
      acc_new = ACC_W'(sum_s);
    end
  end

  // the RAM returns old data when a slot is read on the cycle it is written
  assign byp_nxt = q_pop && ex_valid_r && (q_slot == ex_slot_r);

  assign prod_nxt = PROD_W'(mul_acc_r) * PROD_W'($signed({1'b0, cfg_live.recip}));
  assign base_nxt = BASE_W'(mul_outer_r) * BASE_W'(inner_n);

  always_comb begin
    shifted = fin_prod_r >>> arm_pkg::FRAC_BITS;
    if (shifted > SMP_HI) begin
      mean_val = SMP_HI[SAMPLE_BITS-1:0];
    end else if (shifted < SMP_LO) begin
      mean_val = SMP_LO[SAMPLE_BITS-1:0];
    end else begin
      mean_val = shifted[SAMPLE_BITS-1:0];
    end
    idx_sum = IDX_SUM_W'(fin_base_r) + IDX_SUM_W'(fin_inner_r);
  end

  assign out_push  = fin_valid_r;
  assign out_value = (cfg_live.mode == arm_pkg::MODE_MEAN) ? mean_val : fin_max_r;
  assign out_index = arm_pkg::INDEX_W'(idx_sum);
  assign out_done  = fin_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r  <= 1'b0;
      byp_r       <= 1'b0;
      mul_valid_r <= 1'b0;
      fin_valid_r <= 1'b0;
    end else begin
      ex_valid_r  <= q_pop;
      byp_r       <= byp_nxt;
      mul_valid_r <= ex_valid_r && ex_flags_r.last_red;
      fin_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ex_flags_r  <= q_flags;
      ex_sample_r <= q_sample;
      ex_slot_r   <= q_slot;
      ex_outer_r  <= q_outer;
    end
    byp_data_r  <= acc_new;
    mul_acc_r   <= acc_new;
    mul_inner_r <= ex_slot_r;
    mul_outer_r <= ex_outer_r;
    mul_done_r  <= ex_flags_r.done;
    fin_prod_r  <= prod_nxt;
    fin_base_r  <= base_nxt;
    fin_inner_r <= mul_inner_r;
    fin_max_r   <= mul_acc_r[SAMPLE_BITS-1:0];
    fin_done_r  <= mul_done_r;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> (res_level < OCNT_W'(arm_pkg::OUT_DEPTH)))
    else $error("result pushed into a full queue");

  a_bypass_has_op: assert property (@(posedge clk) disable iff (!rst_n)
    byp_r |-> ex_valid_r)
    else $error("bypass flagged with no operation in execute");

  a_result_from_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    mul_valid_r |-> $past(ex_valid_r && ex_flags_r.last_red))
    else $error("result issued for an element that is not a row end");

  a_bypass_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
    byp_r |-> (ex_slot_r == $past(ex_slot_r, 1) || !$past(ex_valid_r))
              && $past(ex_valid_r))
    else $error("bypass without a write in the previous cycle");

endmodule

@@ hw/rtl/axis_reduce_max_mean_unit.sv @@
// Channel   Handshake                    Payload
// input     push / full                  in_sample
// result    pop / empty                  out_reduced_value, out_result_index, out_tensor_done
// config    cfg_valid / cfg_ready (=1)   cfg_index, cfg_data
//
// One element per cycle sustained while the result side drains; one accumulator RAM port pair
// is used per element, with a write-to-read bypass for back-to-back hits on the same slot.
// An element passes the command queue, then the execute, multiply and finish stages.
// Reset clears positions, queues and settings; the accumulator RAM is not cleared,
// since the first element of each column loads its slot.
// A stalled result side fills the 8-entry result queue, then the 4-entry command
// queue, then raises full.
module axis_reduce_max_mean_unit #(
  parameter int INNER_MAX   = 1024,
  parameter int LENGTH_MAX  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic [SAMPLE_BITS-1:0]            in_sample,
  output logic                              empty,
  input  logic                              pop,
  output logic [SAMPLE_BITS-1:0]            out_reduced_value,
  output logic [arm_pkg::INDEX_W-1:0]       out_result_index,
  output logic                              out_tensor_done,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [arm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [arm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int INNER_W   = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
  localparam int INNER_N_W = $clog2(INNER_MAX + 1);
  localparam int OW        = arm_pkg::OUTER_W;
  localparam int FW        = arm_pkg::FLAGS_W;
  localparam int CMD_W     = FW + SAMPLE_BITS + INNER_W + OW;
  localparam int RES_W     = SAMPLE_BITS + arm_pkg::INDEX_W + 1;
  localparam int OCNT_W    = $clog2(arm_pkg::OUT_DEPTH + 1);

  arm_pkg::cmd_flags_t     f_flags, b_flags;
  arm_pkg::cfg_live_t      cfg_live;
  logic [INNER_N_W-1:0]    inner_n;
  logic [INNER_W-1:0]      f_slot, b_slot;
  logic [OW-1:0]           f_outer, b_outer;
  logic                    cq_push, cq_full, cq_pop, cq_empty;
  logic [CMD_W-1:0]        cq_wdata, cq_rdata;
  logic signed [SAMPLE_BITS-1:0] b_sample;

  logic                    rq_push, rq_full;
  logic [RES_W-1:0]        rq_wdata, rq_rdata;
  logic [OCNT_W-1:0]       rq_count;
  logic [SAMPLE_BITS-1:0]  res_value;
  logic [arm_pkg::INDEX_W-1:0] res_index;
  logic                    res_done;

  assign cfg_ready = 1'b1;

  arm_front #(
    .INNER_MAX  (INNER_MAX),
    .LENGTH_MAX (LENGTH_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .q_full    (cq_full),
    .q_push    (cq_push),
    .q_flags   (f_flags),
    .q_slot    (f_slot),
    .q_outer   (f_outer),
    .cfg_live  (cfg_live),
    .inner_n   (inner_n)
  );

  assign cq_wdata = {f_flags, in_sample, f_slot, f_outer};

  arm_fifo #(
    .W     (CMD_W),
    .DEPTH (arm_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .wdata (cq_wdata),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .empty (cq_empty),
    .count ()
  );

  assign b_flags  = arm_pkg::cmd_flags_t'(cq_rdata[CMD_W-1 -: FW]);
  assign b_sample = $signed(cq_rdata[INNER_W+OW +: SAMPLE_BITS]);
  assign b_slot   = cq_rdata[OW +: INNER_W];
  assign b_outer  = cq_rdata[OW-1:0];

  arm_back #(
    .INNER_MAX   (INNER_MAX),
    .LENGTH_MAX  (LENGTH_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_live  (cfg_live),
    .inner_n   (inner_n),
    .q_empty   (cq_empty),
    .q_pop     (cq_pop),
    .q_flags   (b_flags),
    .q_sample  (b_sample),
    .q_slot    (b_slot),
    .q_outer   (b_outer),
    .res_level (rq_count),
    .out_push  (rq_push),
    .out_value (res_value),
    .out_index (res_index),
    .out_done  (res_done)
  );

  assign rq_wdata = {res_value, res_index, res_done};

  arm_fifo #(
    .W     (RES_W),
    .DEPTH (arm_pkg::OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata (rq_wdata),
    .full  (rq_full),
    .pop   (pop),
    .rdata (rq_rdata),
    .empty (empty),
    .count (rq_count)
  );

  assign out_reduced_value = rq_rdata[RES_W-1 -: SAMPLE_BITS];
  assign out_result_index  = rq_rdata[arm_pkg::INDEX_W:1];
  assign out_tensor_done   = rq_rdata[0];

  a_res_q_room: assert property (@(posedge clk) disable iff (!rst_n)
    rq_push |-> !rq_full)
    else $error("result queue overrun");

endmodule

@@ tb/tb_axis_reduce_max_mean_unit.sv @@
module tb_axis_reduce_max_mean_unit;

  localparam int SW = 16;
  localparam int DW = arm_pkg::CFG_DATA_W;
  localparam int RW = arm_pkg::RECIP_W;
  localparam int DRAIN_CYCLES = 32;
  localparam logic [arm_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int COLS_MAX = 1024;
  localparam int LEN_MAX = 4096;

  typedef struct {
    logic [SW-1:0]               value;
    logic [arm_pkg::INDEX_W-1:0] index;
    logic                        done;
  } reduced_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [SW-1:0] in_sample = '0;
  logic empty;
  logic pop = 1'b0;
  logic [SW-1:0] out_reduced_value;
  logic [arm_pkg::INDEX_W-1:0] out_result_index;
  logic out_tensor_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [arm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [arm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  axis_reduce_max_mean_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_sample(in_sample),
    .empty(empty), .pop(pop),
    .out_reduced_value(out_reduced_value), .out_result_index(out_result_index),
    .out_tensor_done(out_tensor_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow settings and column state
  logic mode_r = arm_pkg::MODE_MAX;
  logic [arm_pkg::OUTER_W-1:0] outer_r = 1;
  logic [arm_pkg::RED_CNT_W-1:0] len_r = 1;
  logic [arm_pkg::INNER_CNT_W-1:0] inner_r = 1;
  logic [arm_pkg::RECIP_W-1:0] recip_r = arm_pkg::RECIP_ONE;
  logic signed [63:0] column_acc [COLS_MAX];
  bit slot_written [COLS_MAX];
  int unsigned inner_pos = 0, red_pos = 0, outer_pos = 0;

  logic [SW-1:0] pending_samples [$];
  reduced_t expected_results [$];
  reduced_t head;
  bit idle_on = 1'b0;
  int gap_left = 0, stall_left = 0;
  int n_mismatch = 0, n_checked = 0, n_sent = 0, n_phases = 0;

  task automatic flag_mismatch(input string what);
    $display("mismatch @%0t: %s", $time, what);
    n_mismatch++;
  endtask

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return SW'($urandom_range(0, 16)) - 16'd8;
      default: return SW'($urandom);
    endcase
  endfunction

  // fold one element into its column and predict the emitted result, if any
  task automatic reduce_element(input logic [SW-1:0] s);
    int unsigned outer_n, len_n, inner_n, slot;
    logic signed [63:0] x, r, sum, rc;
    longint unsigned flat;
    bit last_inner, last_red, last_outer;
    reduced_t e;
    outer_n = (outer_r == 0) ? 1 : outer_r;
    len_n = (len_r == 0) ? 1 : ((len_r > LEN_MAX) ? LEN_MAX : len_r);
    inner_n = (inner_r == 0) ? 1 : ((inner_r > COLS_MAX) ? COLS_MAX : inner_r);
    slot = inner_pos % COLS_MAX;
    x = {{(64-SW){s[SW-1]}}, s};
    last_inner = (inner_pos + 1 >= inner_n);
    last_red = (red_pos + 1 >= len_n);
    last_outer = (outer_pos + 1 >= outer_n);
    if (red_pos == 0) begin
      column_acc[slot] = x;
    end else if (mode_r == arm_pkg::MODE_MAX) begin
      if (x > column_acc[slot]) column_acc[slot] = x;
    end else begin
      sum = column_acc[slot] + x;
      if (sum > arm_pkg::ACC_LIMIT) sum = arm_pkg::ACC_LIMIT;
      else if (sum < -arm_pkg::ACC_LIMIT) sum = -arm_pkg::ACC_LIMIT;
      column_acc[slot] = sum;
    end
    slot_written[slot] = 1'b1;
    if (last_red) begin
      r = column_acc[slot];
      if (mode_r == arm_pkg::MODE_MEAN) begin
        rc = {47'd0, (recip_r > arm_pkg::RECIP_ONE) ? arm_pkg::RECIP_ONE : recip_r};
        r = (r * rc) >>> arm_pkg::FRAC_BITS;
        if (r > 64'sd32767) r = 64'sd32767;
        else if (r < -64'sd32768) r = -64'sd32768;
      end
      flat = longint'(outer_pos) * inner_n + inner_pos;
      e.value = r[SW-1:0];
      e.index = flat[arm_pkg::INDEX_W-1:0];
      e.done = last_inner && last_outer;
      expected_results.push_back(e);
    end
    if (!last_inner) begin
      inner_pos++;
    end else begin
      inner_pos = 0;
      if (!last_red) begin
        red_pos++;
      end else begin
        red_pos = 0;
        outer_pos = last_outer ? 0 : outer_pos + 1;
      end
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        reduce_element(in_sample);
        n_sent++;
      end
      if (!(push && full)) begin
        if (gap_left > 0) begin
          push <= 1'b0;
          gap_left--;
        end else if (pending_samples.size() > 0) begin
          push <= 1'b1;
          in_sample <= pending_samples.pop_front();
          gap_left = idle_gap();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result value=%h index=%0d",
                                  out_reduced_value, out_result_index));
        end else begin
          head = expected_results.pop_front();
          n_checked++;
          if (out_reduced_value !== head.value)
            flag_mismatch($sformatf("index %0d: value %h, want %h",
                                    head.index, out_reduced_value, head.value));
          if (out_result_index !== head.index)
            flag_mismatch($sformatf("result_index %0d, want %0d",
                                    out_result_index, head.index));
          if (out_tensor_done !== head.done)
            flag_mismatch($sformatf("index %0d: tensor_done %b, want %b",
                                    head.index, out_tensor_done, head.done));
        end
        stall_left = idle_gap();
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic cfg_write(input logic [arm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [arm_pkg::CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      arm_pkg::REG_MODE:         mode_r = d[0];
      arm_pkg::REG_OUTER_COUNT:  outer_r = d[arm_pkg::OUTER_W-1:0];
      arm_pkg::REG_REDUCED_LEN:  len_r = d[arm_pkg::RED_CNT_W-1:0];
      arm_pkg::REG_INNER_COUNT:  inner_r = d[arm_pkg::INNER_CNT_W-1:0];
      arm_pkg::REG_LENGTH_RECIP: recip_r = d[arm_pkg::RECIP_W-1:0];
      default: ;
    endcase
  endtask

  // hold until every request is taken and every result is back, then let the pipe empty
  task automatic wait_idle();
    while (pending_samples.size() != 0 || push || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    n_phases++;
  endtask

  task automatic queue_samples(input int n);
    for (int i = 0; i < n; i++) pending_samples.push_back(pick_sample());
  endtask

  initial begin
    int inner_v, len_v, outer_v, tensor, n_items, random_items;
    logic [arm_pkg::RECIP_W-1:0] recip_v;
    bit cols_ready;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: every element gives its own result
    pending_samples.push_back(16'h7FFF);
    pending_samples.push_back(16'h8000);
    pending_samples.push_back(16'h0000);
    wait_idle();

    // mean saturation both ways; reciprocal above one, zero counts, junk above mode bit
    cfg_write(arm_pkg::REG_MODE, 17'h1FFFF);
    cfg_write(arm_pkg::REG_REDUCED_LEN, 4);
    cfg_write(arm_pkg::REG_LENGTH_RECIP, 17'h1FFFF);
    cfg_write(arm_pkg::REG_INNER_COUNT, 0);
    cfg_write(arm_pkg::REG_OUTER_COUNT, 0);
    repeat (4) pending_samples.push_back(16'h7FFF);
    repeat (4) pending_samples.push_back(16'h8000);
    wait_idle();

    // settings changed in the middle of a tensor
    cfg_write(arm_pkg::REG_MODE, {16'h0, arm_pkg::MODE_MAX});
    cfg_write(arm_pkg::REG_LENGTH_RECIP, 21845);
    cfg_write(arm_pkg::REG_REDUCED_LEN, 3);
    cfg_write(arm_pkg::REG_INNER_COUNT, 2);
    cfg_write(arm_pkg::REG_OUTER_COUNT, 2);
    pending_samples.push_back(16'h0100);
    pending_samples.push_back(16'hFF00);
    pending_samples.push_back(16'h7FFF);
    pending_samples.push_back(16'h8000);
    wait_idle();
    cfg_write(arm_pkg::REG_MODE, {16'h0, arm_pkg::MODE_MEAN});
    cfg_write(arm_pkg::REG_REDUCED_LEN, 2);
    cfg_write(arm_pkg::REG_LENGTH_RECIP, 32768);
    queue_samples(2);
    wait_idle();
    cfg_write(REG_UNMAPPED, 17'h1FFFF);
    queue_samples(4);
    wait_idle();

    // large outer count, then shrink it under a running tensor
    idle_on = 1'b1;
    cfg_write(arm_pkg::REG_MODE, {16'h0, arm_pkg::MODE_MAX});
    cfg_write(arm_pkg::REG_REDUCED_LEN, 1);
    cfg_write(arm_pkg::REG_INNER_COUNT, 1);
    cfg_write(arm_pkg::REG_OUTER_COUNT, 65535);
    queue_samples(20);
    wait_idle();
    cfg_write(arm_pkg::REG_OUTER_COUNT, 1);
    queue_samples(1);
    wait_idle();

    // oversized reduced length, then cut the axis short under the running column
    idle_on = $urandom_range(0, 1);
    cfg_write(arm_pkg::REG_MODE, {16'h0, arm_pkg::MODE_MEAN});
    cfg_write(arm_pkg::REG_LENGTH_RECIP, 1074);
    cfg_write(arm_pkg::REG_REDUCED_LEN, 8191);
    queue_samples(60);
    wait_idle();
    cfg_write(arm_pkg::REG_REDUCED_LEN, 2);
    queue_samples(1);
    wait_idle();

    // oversized inner count
    idle_on = $urandom_range(0, 1);
    cfg_write(arm_pkg::REG_REDUCED_LEN, 1);
    cfg_write(arm_pkg::REG_LENGTH_RECIP, 32768);
    cfg_write(arm_pkg::REG_INNER_COUNT, 2047);
    queue_samples(COLS_MAX);
    wait_idle();

    random_items = 0;
    while (random_items < 150) begin
      idle_on = ($urandom_range(0, 3) != 0);
      inner_v = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      len_v = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      outer_v = $urandom_range(1, 3);
      if (outer_v * len_v * inner_v > 120) outer_v = 1;
      if (len_v * inner_v > 120) len_v = 120 / inner_v;
      case ($urandom_range(0, 9))
        0: recip_v = 0;
        1: recip_v = arm_pkg::RECIP_ONE;
        2: recip_v = RW'($urandom);
        3: recip_v = RW'($urandom_range(0, 65536));
        default: recip_v = RW'(65536 / len_v);
      endcase
      cfg_write(arm_pkg::REG_MODE,
                DW'((DW'($urandom) & 17'h1FFFE) | $urandom_range(0, 1)));
      cfg_write(arm_pkg::REG_OUTER_COUNT,
                DW'((outer_v == 1 && $urandom_range(0, 3) == 0) ? 0 : outer_v));
      cfg_write(arm_pkg::REG_REDUCED_LEN,
                DW'((len_v == 1 && $urandom_range(0, 3) == 0) ? 0 : len_v));
      // a column past the old width must not be read before its first load
      cols_ready = 1'b1;
      if (red_pos != 0)
        for (int i = 0; i < inner_v; i++) if (!slot_written[i]) cols_ready = 1'b0;
      if (cols_ready)
        cfg_write(arm_pkg::REG_INNER_COUNT,
                  DW'((inner_v == 1 && $urandom_range(0, 3) == 0) ? 0 : inner_v));
      cfg_write(arm_pkg::REG_LENGTH_RECIP, recip_v);
      tensor = outer_v * len_v * inner_v;
      n_items = ($urandom_range(0, 6) == 0) ? $urandom_range(1, tensor)
                                            : tensor * $urandom_range(1, 2);
      queue_samples(n_items);
      random_items += n_items;
      wait_idle();
    end

    if (expected_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("run: %0d elements sent, %0d results checked over %0d phases",
             n_sent, n_checked, n_phases);
    $display("run: max and mean, zero and oversized counts, mid-tensor updates, gaps, stalls");
    if (n_mismatch == 0) begin
      $display("tb_axis_reduce_max_mean_unit OK");
    end else begin
      $display("tb_axis_reduce_max_mean_unit NOT OK");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("timeout after %0d results", n_checked);
    $display("tb_axis_reduce_max_mean_unit NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/arm_pkg.sv
hw/rtl/arm_ram.sv
hw/rtl/arm_fifo.sv
hw/rtl/arm_front.sv
hw/rtl/arm_back.sv
hw/rtl/axis_reduce_max_mean_unit.sv
tb/tb_axis_reduce_max_mean_unit.sv
